// ----- design/triangle_transform_normal_defines.svh -----
// assertion macros for the triangle transform block
// used by the port checker; expects clock and reset in scope
`ifndef TRIANGLE_TRANSFORM_NORMAL_DEFINES_SVH
`define TRIANGLE_TRANSFORM_NORMAL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TRIXF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trixf check failed");

// next-cycle implication, disabled during reset
`define TRIXF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trixf check failed");

`endif

// ----- design/trixf_pkg.sv -----
// shared types, constants and arithmetic helpers of the triangle transform block
// no dependencies
`default_nettype none

package trixf_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_W    = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_CSR   = 6;
   localparam int PART_W    = 2;
   localparam int IDX_W     = 32;
   localparam int OPND_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int TOP_W     = ACC_W - (COORD_W - 1 + FRAC_W);

   // record part codes
   localparam logic [PART_W-1:0] PART_NORMAL = 2'd0;
   localparam logic [PART_W-1:0] PART_V1     = 2'd1;
   localparam logic [PART_W-1:0] PART_V2     = 2'd2;
   localparam logic [PART_W-1:0] PART_V3     = 2'd3;

   // reset values give the identity matrix
   localparam logic [CSR_W-1:0] CSR_RESET [NUM_CSR] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000,
      64'h0, 64'h0, 64'h0000_0000_0001_0000};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NUM_CSR-1:0][CSR_W-1:0] csr_bank_type;

   typedef struct packed {
      coord_type a_x, a_y, a_z;
      coord_type b_x, b_y, b_z;
      coord_type c_x, c_y, c_z;
      logic [IDX_W-1:0] facet;
   } qent_type;

   // matrix coefficient m[r][c], c = 3 is the translation
   function automatic coord_type coef(input csr_bank_type bank,
                                      input logic [1:0] r, input logic [1:0] c);
      logic [2:0]       idx;
      logic [CSR_W-1:0] word;
      idx  = {r, 1'b0} + {2'b00, c[1]};
      word = bank[idx];
      return c[0] ? word[CSR_W-1:COORD_W] : word[COORD_W-1:0];
   endfunction

   // arithmetic shift right by the fraction bits, then saturate
   function automatic coord_type rescale_sat(input logic signed [ACC_W-1:0] a);
      logic [TOP_W-1:0] top;
      top = a[ACC_W-1:COORD_W-1+FRAC_W];
      if (top == '0 || top == '1)
         return a[COORD_W-1+FRAC_W:FRAC_W];
      else if (a[ACC_W-1])
         return {1'b1, {(COORD_W-1){1'b0}}};
      else
         return {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   // cross product term order: row r, term t gives u[ui] * w[wi]
   function automatic logic [1:0] nrm_u_idx(input logic [1:0] r, input logic t);
      logic [2:0] s;
      s = {1'b0, r} + 3'd1 + {2'b00, t};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   function automatic logic [1:0] nrm_w_idx(input logic [1:0] r, input logic t);
      logic [2:0] s;
      s = {1'b0, r} + 3'd2 - {2'b00, t};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/trixf_if.sv -----
// channel interfaces of the triangle transform block: request, response, csr write
// depends on trixf_pkg
`default_nettype none

interface trixf_req_if;
   logic valid;
   logic ready;
   trixf_pkg::coord_type a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface trixf_rsp_if;
   logic valid;
   logic ready;
   trixf_pkg::coord_type out_x, out_y, out_z;
   logic [trixf_pkg::PART_W-1:0] record_part;
   logic last;
   logic [trixf_pkg::IDX_W-1:0] facet_index;
   modport source (output valid, out_x, out_y, out_z, record_part, last, facet_index,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, record_part, last, facet_index,
                 output ready);
endinterface

interface trixf_csr_if;
   logic valid;
   logic ready;
   logic [trixf_pkg::CSR_IDX_W-1:0] index;
   logic [trixf_pkg::CSR_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/triangle_transform_normal.sv -----
// top level of the triangle transform block: matrix registers, front queue, back end
// depends on trixf_pkg, trixf_if, trixf_front and trixf_back
`default_nettype none

// Takes a triangle per request beat and returns four response beats: the face
// normal, then the three vertices through the affine matrix, all tagged with the
// facet index. A triangle passes through the back end in order: a load step, the
// products for the nine matrix rows on one shared 33x33 multiplier, a drain step,
// the edge vectors, the cross product on the same multiplier, a drain step and
// the four output beats, which the response side can stall.
// A two-entry queue in front keeps up to two further triangles waiting. Matrix
// registers are written through the csr channel, which is always ready.
module triangle_transform_normal (
   input wire logic clock,
   input wire logic reset,
   trixf_req_if.sink   req_ch,
   trixf_rsp_if.source rsp_ch,
   trixf_csr_if.sink   csr_ch
);

   trixf_pkg::csr_bank_type bank_ff;
   trixf_pkg::qent_type     q_head;
   logic                    q_vld;
   logic                    q_pop;

   assign csr_ch.ready = 1'b1;

   // matrix register bank, writes beyond the last row are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < trixf_pkg::NUM_CSR; i++) bank_ff[i] <= trixf_pkg::CSR_RESET[i];
      end else if (csr_ch.valid &&
                   csr_ch.index < trixf_pkg::CSR_IDX_W'(trixf_pkg::NUM_CSR)) begin
         bank_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   trixf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_head (q_head),
      .q_vld  (q_vld),
      .q_pop  (q_pop)
   );

   trixf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .bank   (bank_ff),
      .q_head (q_head),
      .q_vld  (q_vld),
      .q_pop  (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/trixf_front.sv -----
// front end: accepts triangle beats, tags them with the facet index, queues them
// depends on trixf_pkg and trixf_if
`default_nettype none

module trixf_front (
   input  wire logic          clock,
   input  wire logic          reset,
   trixf_req_if.sink          req_ch,
   output trixf_pkg::qent_type q_head,
   output logic               q_vld,
   input  wire logic          q_pop
);

   trixf_pkg::qent_type mem_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [trixf_pkg::IDX_W-1:0] facet_ff, facet_in;
   logic                      push;
   logic                      pop;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = q_pop && q_vld;
   assign q_vld  = (cnt_ff != 2'd0);
   assign q_head = mem_ff[rd_ptr_ff];

   // pointer, count and facet counter update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      facet_in  = push ? facet_ff + 32'd1 : facet_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         facet_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         facet_ff  <= facet_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{a_x: req_ch.a_x, a_y: req_ch.a_y, a_z: req_ch.a_z,
                                b_x: req_ch.b_x, b_y: req_ch.b_y, b_z: req_ch.b_z,
                                c_x: req_ch.c_x, c_y: req_ch.c_y, c_z: req_ch.c_z,
                                facet: facet_ff};
      end
   end

endmodule

`default_nettype wire

// ----- design/trixf_back.sv -----
// back end: shared multiply-accumulate sequencer for transform and normal, output stage
// depends on trixf_pkg and trixf_if
`default_nettype none

module trixf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trixf_pkg::csr_bank_type bank,
   input  wire trixf_pkg::qent_type   q_head,
   input  wire logic                  q_vld,
   output logic                       q_pop,
   trixf_rsp_if.source                rsp_ch
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_XFORM = 3'd1;
   localparam logic [2:0] ST_XWAIT = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_NORM  = 3'd4;
   localparam logic [2:0] ST_NWAIT = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] vtx_ff, vtx_in, row_ff, row_in, col_ff, col_in;
   logic [trixf_pkg::PART_W-1:0] part_ff, part_in;
   trixf_pkg::qent_type tri_ff;

   trixf_pkg::coord_type vert [3][3];
   trixf_pkg::coord_type t_ff [3][3];
   trixf_pkg::coord_type n_ff [3];
   logic signed [trixf_pkg::OPND_W-1:0] u_ff [3];
   logic signed [trixf_pkg::OPND_W-1:0] w_ff [3];

   logic signed [trixf_pkg::OPND_W-1:0] mul_a, mul_b;
   logic signed [trixf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [trixf_pkg::ACC_W-1:0]  acc_ff, sum, init, prod_ext;
   trixf_pkg::coord_type                 a_coef, v_coord, tr_coef, res;

   logic issue, is_first, is_last, is_neg;
   logic tg_vld_ff, tg_first_ff, tg_last_ff, tg_neg_ff, tg_nrm_ff;
   logic [1:0] tg_vtx_ff, tg_row_ff;

   logic rsp_vld_ff;
   logic out_free;
   trixf_pkg::coord_type rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [trixf_pkg::IDX_W-1:0] rsp_idx_ff;
   logic [trixf_pkg::PART_W-1:0] rsp_part_ff;

   assign vert[0][0] = tri_ff.a_x;
   assign vert[0][1] = tri_ff.a_y;
   assign vert[0][2] = tri_ff.a_z;
   assign vert[1][0] = tri_ff.b_x;
   assign vert[1][1] = tri_ff.b_y;
   assign vert[1][2] = tri_ff.b_z;
   assign vert[2][0] = tri_ff.c_x;
   assign vert[2][1] = tri_ff.c_y;
   assign vert[2][2] = tri_ff.c_z;

   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_vld;

   // operand selection for the shared multiplier
   always_comb begin
      a_coef  = trixf_pkg::coef(bank, row_ff, col_ff);
      v_coord = vert[vtx_ff][col_ff];
      if (state_ff == ST_NORM) begin
         mul_a = u_ff[trixf_pkg::nrm_u_idx(row_ff, col_ff[0])];
         mul_b = w_ff[trixf_pkg::nrm_w_idx(row_ff, col_ff[0])];
      end else begin
         mul_a = {a_coef[trixf_pkg::COORD_W-1], a_coef};
         mul_b = {v_coord[trixf_pkg::COORD_W-1], v_coord};
      end
      prod_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      vtx_in   = vtx_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      part_in  = part_ff;
      issue    = 1'b0;
      is_first = 1'b0;
      is_last  = 1'b0;
      is_neg   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            vtx_in  = 2'd0;
            row_in  = 2'd0;
            col_in  = 2'd0;
            part_in = trixf_pkg::PART_NORMAL;
            if (q_vld) state_in = ST_XFORM;
         end
         ST_XFORM: begin
            issue    = 1'b1;
            is_first = (col_ff == 2'd0);
            is_last  = (col_ff == 2'd2);
            if (col_ff != 2'd2) begin
               col_in = col_ff + 2'd1;
            end else begin
               col_in = 2'd0;
               if (row_ff != 2'd2) begin
                  row_in = row_ff + 2'd1;
               end else begin
                  row_in = 2'd0;
                  if (vtx_ff != 2'd2) vtx_in = vtx_ff + 2'd1;
                  else state_in = ST_XWAIT;
               end
            end
         end
         ST_XWAIT: state_in = ST_DIFF;
         ST_DIFF: begin
            row_in   = 2'd0;
            col_in   = 2'd0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            issue    = 1'b1;
            is_first = !col_ff[0];
            is_last  = col_ff[0];
            is_neg   = col_ff[0];
            col_in   = {1'b0, !col_ff[0]};
            if (col_ff[0]) begin
               if (row_ff != 2'd2) row_in = row_ff + 2'd1;
               else state_in = ST_NWAIT;
            end
         end
         ST_NWAIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               part_in = part_ff + 2'd1;
               if (part_ff == trixf_pkg::PART_V3) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tg_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tg_vld_ff <= issue;
      end
   end

   // counters, operand pipeline and tags
   always_ff @(posedge clock) begin
      vtx_ff      <= vtx_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      part_ff     <= part_in;
      prod_ff     <= prod_in;
      tg_first_ff <= is_first;
      tg_last_ff  <= is_last;
      tg_neg_ff   <= is_neg;
      tg_nrm_ff   <= (state_ff == ST_NORM);
      tg_vtx_ff   <= vtx_ff;
      tg_row_ff   <= row_ff;
      if (q_pop) tri_ff <= q_head;
   end

   // accumulate, rescale and saturate
   always_comb begin
      tr_coef  = trixf_pkg::coef(bank, tg_row_ff, 2'd3);
      prod_ext = {{2{prod_ff[trixf_pkg::PROD_W-1]}}, prod_ff};
      if (!tg_first_ff)
         init = acc_ff;
      else if (tg_nrm_ff)
         init = '0;
      else
         init = {{(trixf_pkg::ACC_W-trixf_pkg::COORD_W-trixf_pkg::FRAC_W)
                  {tr_coef[trixf_pkg::COORD_W-1]}},
                 tr_coef, {trixf_pkg::FRAC_W{1'b0}}};
      sum = tg_neg_ff ? init - prod_ext : init + prod_ext;
      res = trixf_pkg::rescale_sat(sum);
   end

   always_ff @(posedge clock) begin
      if (tg_vld_ff) acc_ff <= sum;
      if (tg_vld_ff && tg_last_ff) begin
         if (tg_nrm_ff) n_ff[tg_row_ff] <= res;
         else t_ff[tg_vtx_ff][tg_row_ff] <= res;
      end
   end

   // edge vectors of the transformed triangle
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         for (int j = 0; j < 3; j++) begin
            u_ff[j] <= {t_ff[1][j][trixf_pkg::COORD_W-1], t_ff[1][j]}
                     - {t_ff[0][j][trixf_pkg::COORD_W-1], t_ff[0][j]};
            w_ff[j] <= {t_ff[2][j][trixf_pkg::COORD_W-1], t_ff[2][j]}
                     - {t_ff[0][j][trixf_pkg::COORD_W-1], t_ff[0][j]};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_part_ff <= part_ff;
         rsp_idx_ff  <= tri_ff.facet;
         if (part_ff == trixf_pkg::PART_NORMAL) begin
            rsp_x_ff <= n_ff[0];
            rsp_y_ff <= n_ff[1];
            rsp_z_ff <= n_ff[2];
         end else begin
            rsp_x_ff <= t_ff[part_ff - 2'd1][0];
            rsp_y_ff <= t_ff[part_ff - 2'd1][1];
            rsp_z_ff <= t_ff[part_ff - 2'd1][2];
         end
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.out_x       = rsp_x_ff;
   assign rsp_ch.out_y       = rsp_y_ff;
   assign rsp_ch.out_z       = rsp_z_ff;
   assign rsp_ch.record_part = rsp_part_ff;
   assign rsp_ch.last        = (rsp_part_ff == trixf_pkg::PART_V3);
   assign rsp_ch.facet_index = rsp_idx_ff;

endmodule

`default_nettype wire

// ----- design/trixf_checker.sv -----
// port checker of the triangle transform block and its bind to the top level
// depends on trixf_pkg and triangle_transform_normal_defines.svh
`default_nettype none
`include "triangle_transform_normal_defines.svh"

module trixf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [trixf_pkg::PART_W-1:0] rsp_record_part,
   input wire logic rsp_last,
   input wire logic [trixf_pkg::IDX_W-1:0] rsp_facet_index
);

   logic [trixf_pkg::PART_W-1:0] exp_part_ff;
   logic [trixf_pkg::IDX_W-1:0]  facet_ff;
   logic                         seen_ff;

   // track the last accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_part_ff <= trixf_pkg::PART_NORMAL;
         seen_ff     <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         exp_part_ff <= rsp_record_part + 2'd1;
         seen_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) facet_ff <= rsp_facet_index;
   end

   `TRIXF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_record_part) && $stable(rsp_facet_index))
   `TRIXF_ASSERT_IMPL(a_last_part, rsp_valid, rsp_last == (rsp_record_part == trixf_pkg::PART_V3))
   `TRIXF_ASSERT_IMPL(a_part_order, rsp_valid, rsp_record_part == exp_part_ff)
   `TRIXF_ASSERT_IMPL(a_facet_same, rsp_valid && seen_ff && rsp_record_part != trixf_pkg::PART_NORMAL, rsp_facet_index == facet_ff)
   `TRIXF_ASSERT_IMPL(a_facet_next, rsp_valid && seen_ff && rsp_record_part == trixf_pkg::PART_NORMAL, rsp_facet_index == facet_ff + 32'd1)

endmodule

bind triangle_transform_normal trixf_checker u_trixf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_record_part (rsp_ch.record_part),
   .rsp_last        (rsp_ch.last),
   .rsp_facet_index (rsp_ch.facet_index)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking bench for triangle_transform_normal: triangles in, normal and vertex beats out
// depends on trixf_pkg, trixf_if and the design files
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   typedef struct {
      trixf_pkg::coord_type v [3][3];
   } triangle_type;

   typedef struct {
      trixf_pkg::coord_type               x, y, z;
      logic [trixf_pkg::PART_W-1:0]       part;
      logic                               last;
      logic [trixf_pkg::IDX_W-1:0]        facet;
   } record_type;

   localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;

   trixf_req_if req_ch ();
   trixf_rsp_if rsp_ch ();
   trixf_csr_if csr_ch ();

   triangle_transform_normal dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // bench copy of the matrix and the facet counter
   logic [trixf_pkg::CSR_W-1:0] matrix_regs [trixf_pkg::NUM_CSR];
   logic [trixf_pkg::IDX_W-1:0] facet_count;

   triangle_type tri_pending [$];
   record_type   records_due [$];
   triangle_type cur_tri;

   int errors = 0;
   int tri_sent = 0;
   int rec_seen = 0;
   int csr_writes = 0;
   int sat_seen = 0;
   bit hold_done = 0;

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // append to the tail of the pending and expected queues
   function automatic void add_record(input record_type rec);
      records_due.insert(records_due.size(), rec);
   endfunction

   function automatic void add_tri(input triangle_type t);
      tri_pending.insert(tri_pending.size(), t);
   endfunction

   // rescale by the fraction bits, then clamp to the coordinate range
   function automatic trixf_pkg::coord_type shift_clamp(input logic signed [127:0] s);
      logic signed [127:0] q;
      q = s >>> trixf_pkg::FRAC_W;
      if (q > SAT_HI) return SAT_HI[trixf_pkg::COORD_W-1:0];
      if (q < SAT_LO) return SAT_LO[trixf_pkg::COORD_W-1:0];
      return q[trixf_pkg::COORD_W-1:0];
   endfunction

   function automatic trixf_pkg::coord_type matrix_coef(input int r, input int c);
      logic [trixf_pkg::CSR_W-1:0] word;
      word = matrix_regs[r * 2 + c / 2];
      return (c % 2) ? word[trixf_pkg::CSR_W-1:trixf_pkg::COORD_W]
                     : word[trixf_pkg::COORD_W-1:0];
   endfunction

   // four records of one facet: normal first, then the mapped vertices
   function automatic void predict_facet(input triangle_type t);
      trixf_pkg::coord_type tv [3][3];
      trixf_pkg::coord_type nrm [3];
      logic signed [127:0]  acc, u [3], w [3];
      logic signed [127:0]  m0, m1, m2, m3, px, py, pz;
      record_type           rec;
      for (int i = 0; i < 3; i++) begin
         for (int r = 0; r < 3; r++) begin
            m0 = matrix_coef(r, 0);
            m1 = matrix_coef(r, 1);
            m2 = matrix_coef(r, 2);
            m3 = matrix_coef(r, 3);
            px = t.v[i][0];
            py = t.v[i][1];
            pz = t.v[i][2];
            acc = (m3 <<< trixf_pkg::FRAC_W) + m0 * px + m1 * py + m2 * pz;
            tv[i][r] = shift_clamp(acc);
         end
      end
      for (int j = 0; j < 3; j++) begin
         u[j] = 128'(tv[1][j]) - 128'(tv[0][j]);
         w[j] = 128'(tv[2][j]) - 128'(tv[0][j]);
      end
      nrm[0] = shift_clamp(u[1] * w[2] - u[2] * w[1]);
      nrm[1] = shift_clamp(u[2] * w[0] - u[0] * w[2]);
      nrm[2] = shift_clamp(u[0] * w[1] - u[1] * w[0]);
      rec.facet = facet_count;
      rec.x = nrm[0];
      rec.y = nrm[1];
      rec.z = nrm[2];
      rec.part = trixf_pkg::PART_NORMAL;
      rec.last = 1'b0;
      add_record(rec);
      for (int i = 0; i < 3; i++) begin
         rec.x = tv[i][0];
         rec.y = tv[i][1];
         rec.z = tv[i][2];
         rec.part = (i == 0) ? trixf_pkg::PART_V1 :
                    (i == 1) ? trixf_pkg::PART_V2 : trixf_pkg::PART_V3;
         rec.last = (i == 2);
         add_record(rec);
      end
      facet_count = facet_count + 1;
   endfunction

   // csr beats update the bench matrix; indexes past the bank are dropped
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < trixf_pkg::NUM_CSR; i++) matrix_regs[i] = trixf_pkg::CSR_RESET[i];
      end else if (csr_ch.valid && csr_ch.ready) begin
         csr_writes++;
         if (csr_ch.index < trixf_pkg::NUM_CSR) matrix_regs[csr_ch.index] = csr_ch.data;
      end
   end

   // request driver: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         facet_count = '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_facet(cur_tri);
            tri_sent++;
            if (burst_left > 0) burst_left--;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (tri_pending.size() > 0) begin
               cur_tri = tri_pending.pop_front();
               req_ch.a_x <= cur_tri.v[0][0];
               req_ch.a_y <= cur_tri.v[0][1];
               req_ch.a_z <= cur_tri.v[0][2];
               req_ch.b_x <= cur_tri.v[1][0];
               req_ch.b_y <= cur_tri.v[1][1];
               req_ch.b_z <= cur_tri.v[1][2];
               req_ch.c_x <= cur_tri.v[2][0];
               req_ch.c_y <= cur_tri.v[2][1];
               req_ch.c_z <= cur_tri.v[2][2];
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response ready: alternating calm and choppy windows, one long hold-off
   int rsp_cycle = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_cycle++;
         if (!hold_done && rec_seen >= 60) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if ((rsp_cycle / 64) % 2 == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // response monitor: every beat against the oldest expected record
   always @(posedge clock) begin
      record_type exp_rec;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rec_seen++;
         if (records_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat part %0d x %h", $time, rsp_ch.record_part,
                     rsp_ch.out_x);
         end else begin
            exp_rec = records_due.pop_front();
            if (rsp_ch.out_x == SAT_HI[31:0] || rsp_ch.out_x == SAT_LO[31:0]) sat_seen++;
            if (rsp_ch.out_x !== exp_rec.x || rsp_ch.out_y !== exp_rec.y ||
                rsp_ch.out_z !== exp_rec.z || rsp_ch.record_part !== exp_rec.part ||
                rsp_ch.last !== exp_rec.last || rsp_ch.facet_index !== exp_rec.facet) begin
               errors++;
               $display("%0t: mismatch expected x %h y %h z %h part %0d last %0d facet %0d",
                        $time, exp_rec.x, exp_rec.y, exp_rec.z, exp_rec.part,
                        exp_rec.last, exp_rec.facet);
               $display("%0t:          actual x %h y %h z %h part %0d last %0d facet %0d",
                        $time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                        rsp_ch.record_part, rsp_ch.last, rsp_ch.facet_index);
            end
         end
      end
   end

   // watchdog on cycles without any beat
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress, %0d records still due", $time, records_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic trixf_pkg::coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic triangle_type make_tri(input trixf_pkg::coord_type a0, a1, a2,
                                             b0, b1, b2, c0, c1, c2);
      triangle_type t;
      t.v[0][0] = a0; t.v[0][1] = a1; t.v[0][2] = a2;
      t.v[1][0] = b0; t.v[1][1] = b1; t.v[1][2] = b2;
      t.v[2][0] = c0; t.v[2][1] = c1; t.v[2][2] = c2;
      return t;
   endfunction

   task automatic queue_random(input int n);
      for (int k = 0; k < n; k++)
         add_tri(make_tri(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord()));
   endtask

   // wait until every queued facet has come back, then a few quiet cycles
   task automatic wait_drained();
      wait (tri_pending.size() == 0 && !req_ch.valid && records_due.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [trixf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [trixf_pkg::CSR_W-1:0] d);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [31:0] small_coef();
      return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   localparam trixf_pkg::coord_type CMAX = 32'h7FFF_FFFF;
   localparam trixf_pkg::coord_type CMIN = 32'h8000_0000;
   localparam trixf_pkg::coord_type ONE  = 32'h0001_0000;

   // stimulus and end of run
   initial begin
      req_ch.valid = 1'b0;
      {req_ch.a_x, req_ch.a_y, req_ch.a_z} = '0;
      {req_ch.b_x, req_ch.b_y, req_ch.b_z} = '0;
      {req_ch.c_x, req_ch.c_y, req_ch.c_z} = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // identity matrix from reset: directed corners first
      add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_tri(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      add_tri(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      add_tri(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
      add_tri(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
      add_tri(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
      add_tri(make_tri(0, 0, 0, CMAX, 0, 0, 0, CMAX, 0));
      add_tri(make_tri(0, 0, 0, CMIN, 0, 0, 0, CMAX, CMAX));
      // collinear points give a zero normal
      add_tri(make_tri(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 3*ONE));
      add_tri(make_tri(-1, -1, -1, 1, 1, 1, 32'hFFFF_0000, 5, 32'h00FF_FF00));
      queue_random(25);
      wait_drained();

      // small random scale and offset, plus writes past the bank
      for (int i = 0; i < trixf_pkg::NUM_CSR; i++)
         write_reg(trixf_pkg::CSR_IDX_W'(i), {small_coef(), small_coef()});
      write_reg(3'd6, {$urandom, $urandom});
      write_reg(3'd7, {$urandom, $urandom});
      queue_random(30);
      wait_drained();

      // all ones
      for (int i = 0; i < trixf_pkg::NUM_CSR; i++)
         write_reg(trixf_pkg::CSR_IDX_W'(i), '1);
      queue_random(20);
      wait_drained();

      // largest magnitudes, forcing saturation on most outputs
      for (int i = 0; i < trixf_pkg::NUM_CSR; i++)
         write_reg(trixf_pkg::CSR_IDX_W'(i), 64'h7FFF_FFFF_8000_0000);
      queue_random(20);
      wait_drained();

      // zero matrix leaves only zeros
      for (int i = 0; i < trixf_pkg::NUM_CSR; i++)
         write_reg(trixf_pkg::CSR_IDX_W'(i), '0);
      queue_random(10);
      wait_drained();

      // fully random matrix
      for (int i = 0; i < trixf_pkg::NUM_CSR; i++)
         write_reg(trixf_pkg::CSR_IDX_W'(i), {$urandom, $urandom});
      queue_random(40);
      wait_drained();

      repeat (50) @(posedge clock);
      $display("covered %0d triangles, %0d records, %0d csr writes, %0d clamped x values",
               tri_sent, rec_seen, csr_writes, sat_seen);
      if (errors == 0 && records_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
